/* src/ciata_pkg.sv */
// Package for the timer A / interrupt unit.
// Types, register address map and constants shared by the core and the top level.
// No dependencies.
package ciata_pkg;

    localparam logic [15:0] RESET_COUNT = 16'hffff;
    localparam logic [4:0]  MASK_RESET  = 5'h1f;
    localparam logic [7:0]  CTRL_WMASK  = 8'hef;
    localparam int          STORE_DEPTH = 16;
    localparam int          ADDR_BITS   = 4;

    localparam logic [3:0] ADDR_LATCH_LO = 4'h4;
    localparam logic [3:0] ADDR_LATCH_HI = 4'h5;
    localparam logic [3:0] ADDR_ICR      = 4'hd;
    localparam logic [3:0] ADDR_CRA      = 4'he;
    localparam logic [3:0] ADDR_CRB      = 4'hf;

    localparam int CRA_START   = 0;
    localparam int CRA_ONESHOT = 3;
    localparam int CRA_LOAD    = 4;
    localparam int ICR_SET     = 7;
    localparam int FLAG_REQ    = 7;
    localparam int FLAG_TA     = 0;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_line;
        logic       timer_underflow;
    } t_result;

endpackage

/* src/ciata_core.sv */
// Timer A, interrupt flag/mask logic, register file and lock register.
// Updates all state but the lock register for one transaction per step and returns its result combinationally.
// Depends on ciata_pkg.
module ciata_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_step,
    input  ciata_pkg::t_item  i_item,
    output ciata_pkg::t_result o_result
);

    logic [15:0] r_count, n_count;
    logic [15:0] r_latch, n_latch;
    logic [7:0]  r_cra, n_cra;
    logic [7:0]  r_crb, n_crb;
    logic [4:0]  r_mask, n_mask;
    logic [7:0]  r_flags, n_flags;
    logic        r_lock;
    logic [7:0]  r_store [ciata_pkg::STORE_DEPTH];

    logic        in_range;
    logic [3:0]  addr;
    logic [7:0]  wdata;
    logic        store_we;
    logic [7:0]  rd;
    logic        uf;
    logic [7:0]  tick_flags;

    always_comb begin
        in_range   = (i_item.reg_addr[7:ciata_pkg::ADDR_BITS] == '0);
        addr       = i_item.reg_addr[ciata_pkg::ADDR_BITS-1:0];
        wdata      = i_item.write_data;
        n_count    = r_count;
        n_latch    = r_latch;
        n_cra      = r_cra;
        n_crb      = r_crb;
        n_mask     = r_mask;
        n_flags    = r_flags;
        store_we   = 1'b0;
        rd         = 8'h00;
        uf         = 1'b0;
        tick_flags = r_flags | 8'h01;
        case (i_item.mode)
            ciata_pkg::MODE_TICK: begin
                if (r_cra[ciata_pkg::CRA_START]) begin
                    if (r_count == 16'h0000) begin
                        uf      = 1'b1;
                        n_count = r_latch;
                        if (r_cra[ciata_pkg::CRA_ONESHOT]) begin
                            n_cra[ciata_pkg::CRA_START] = 1'b0;
                        end
                        n_flags = tick_flags;
                        if ((r_mask & tick_flags[4:0]) != '0) begin
                            n_flags[ciata_pkg::FLAG_REQ] = 1'b1;
                        end
                    end else begin
                        n_count = r_count - 16'd1;
                    end
                end
            end
            ciata_pkg::MODE_READ: begin
                if (in_range) begin
                    case (addr)
                        ciata_pkg::ADDR_LATCH_LO: rd = r_latch[7:0];
                        ciata_pkg::ADDR_LATCH_HI: rd = r_latch[15:8];
                        ciata_pkg::ADDR_ICR: begin
                            rd = r_flags;
                            if (r_flags[ciata_pkg::FLAG_REQ]) begin
                                n_flags = 8'h00;
                            end
                        end
                        ciata_pkg::ADDR_CRA:      rd = r_cra;
                        ciata_pkg::ADDR_CRB:      rd = r_crb;
                        default:                  rd = r_store[addr];
                    endcase
                end
            end
            ciata_pkg::MODE_WRITE: begin
                if (in_range) begin
                    store_we = 1'b1;
                    if (!r_lock) begin
                        case (addr)
                            ciata_pkg::ADDR_LATCH_LO: n_latch = {r_latch[15:8], wdata};
                            ciata_pkg::ADDR_LATCH_HI: begin
                                n_latch = {wdata, r_latch[7:0]};
                                if (!r_cra[ciata_pkg::CRA_START]) begin
                                    n_count = {wdata, r_latch[7:0]};
                                end
                            end
                            ciata_pkg::ADDR_ICR: begin
                                if (wdata[ciata_pkg::ICR_SET]) begin
                                    n_mask = r_mask | wdata[4:0];
                                end else begin
                                    n_mask = r_mask & ~wdata[4:0];
                                end
                                if ((n_mask & r_flags[4:0]) != '0) begin
                                    n_flags[ciata_pkg::FLAG_REQ] = 1'b1;
                                end
                            end
                            ciata_pkg::ADDR_CRA: begin
                                if (wdata[ciata_pkg::CRA_LOAD]) begin
                                    n_count = r_latch;
                                end
                                n_cra = wdata & ciata_pkg::CTRL_WMASK;
                            end
                            ciata_pkg::ADDR_CRB: n_crb = wdata & ciata_pkg::CTRL_WMASK;
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
        o_result.read_data       = rd;
        o_result.irq_line        = n_flags[ciata_pkg::FLAG_REQ];
        o_result.timer_underflow = uf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= ciata_pkg::RESET_COUNT;
            r_latch <= ciata_pkg::RESET_COUNT;
            r_cra   <= 8'h00;
            r_crb   <= 8'h00;
            r_mask  <= ciata_pkg::MASK_RESET;
            r_flags <= 8'h00;
            r_lock  <= 1'b0;
            for (int i = 0; i < ciata_pkg::STORE_DEPTH; i++) begin
                r_store[i] <= 8'h00;
            end
        end else begin
            if (i_cfg_we) begin
                r_lock <= i_cfg_wdata;
            end
            if (i_step) begin
                r_count <= n_count;
                r_latch <= n_latch;
                r_cra   <= n_cra;
                r_crb   <= n_crb;
                r_mask  <= n_mask;
                r_flags <= n_flags;
                if (store_we) begin
                    r_store[addr] <= wdata;
                end
            end
        end
    end

endmodule

/* src/cia_timer_a_interrupt_unit_top.sv */
// Each transaction passes the input register, then the result register.
// Throughput: one transaction per cycle unless stalled; timer/flag state updates as the item
// leaves the input register, so consecutive items see each other's effects.
// Reset (i_rst_n low, synchronous): both stages empty, count and latch 0xffff,
// controls and flags zero, mask 0x1f, readback store zero, lock off.
module cia_timer_a_interrupt_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // [1:0] mode
    input  logic [15:0] s_axis_tdata,  // [7:0] reg_addr, [15:8] write_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [7:0] read_data, [8] irq_line, [9] timer_underflow
);

    logic               r_in_valid;
    ciata_pkg::t_item   r_item;
    logic               r_out_valid;
    ciata_pkg::t_result r_result;
    ciata_pkg::t_result result;
    logic               step;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.mode       <= ciata_pkg::t_mode'(s_axis_tuser);
            r_item.reg_addr   <= s_axis_tdata[7:0];
            r_item.write_data <= s_axis_tdata[15:8];
        end
        if (step) begin
            r_result <= result;
        end
    end

    ciata_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_item      (r_item),
        .o_result    (result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_result.timer_underflow, r_result.irq_line,
                            r_result.read_data};

endmodule

/* src/ciata_chk.sv */
// Port-level checker for the timer A / interrupt unit, bound to the top level.
// Depends only on the top-level ports.
module ciata_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    a_uf_no_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[9]) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("underflow result carries read data");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:10] == 6'b000000))
        else $error("result padding not zero");

    a_empty_after_rst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!m_axis_tvalid && s_axis_tready))
        else $error("pipeline not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind cia_timer_a_interrupt_unit_top ciata_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
